FILE: hw/rtl/aew_pkg.sv
// Types and constants shared by the ADC event word unpacker.
package aew_pkg;

  localparam logic [2:0] TypeDatum   = 3'd0;
  localparam logic [2:0] TypeHeader  = 3'd2;
  localparam logic [2:0] TypeTrailer = 3'd4;
  localparam logic [31:0] FillerWord = 32'hffff_ffff;

  localparam logic [2:0] KindHeader  = 3'd0;
  localparam logic [2:0] KindData    = 3'd1;
  localparam logic [2:0] KindTrailer = 3'd2;
  localparam logic [2:0] KindFiller  = 3'd3;
  localparam logic [2:0] KindError   = 3'd4;

  localparam logic [2:0] ErrNone       = 3'd0;
  localparam logic [2:0] ErrNotHeader  = 3'd1;
  localparam logic [2:0] ErrNotData    = 3'd2;
  localparam logic [2:0] ErrNotTrailer = 3'd3;
  localparam logic [2:0] ErrIncomplete = 3'd4;

  typedef enum logic [2:0] {
    PhSeek  = 3'b001,
    PhData  = 3'b010,
    PhTrail = 3'b100
  } phase_e;

  typedef struct packed {
    logic [31:0] raw_word;
    logic        buffer_last;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  geo_addr;
    logic [7:0]  crate_id;
    logic [5:0]  word_count;
    logic [4:0]  chan_num;
    logic [13:0] conversion;
    logic [23:0] event_counter;
    logic [2:0]  error_code;
    logic        event_done;
  } out_t;

  typedef struct packed {
    phase_e     phase;
    logic [5:0] words_left;
    logic [4:0] held_geo;
    logic [7:0] held_crate;
    logic [5:0] held_count;
  } state_t;

endpackage

FILE: hw/rtl/aew_decode.sv
// Word decoder: result and next parser state for one readout word.
module aew_decode (
  input  aew_pkg::in_t    word_i,
  input  aew_pkg::state_t state_i,
  output aew_pkg::out_t   res_o,
  output aew_pkg::state_t state_o
);

  logic [31:0] w;
  logic [2:0]  wtype;

  assign w     = word_i.raw_word;
  assign wtype = w[26:24];

  always_comb begin
    res_o   = '0;
    state_o = state_i;
    unique case (state_i.phase)
      aew_pkg::PhData: begin
        res_o.geo_addr   = state_i.held_geo;
        res_o.crate_id   = state_i.held_crate;
        res_o.word_count = state_i.held_count;
        if (wtype != aew_pkg::TypeDatum) begin
          res_o.kind       = aew_pkg::KindError;
          res_o.error_code = aew_pkg::ErrNotData;
          state_o.phase    = aew_pkg::PhSeek;
        end else begin
          res_o.chan_num   = w[20:16];
          res_o.conversion = w[13:0];
          if (word_i.buffer_last) begin
            res_o.kind       = aew_pkg::KindError;
            res_o.error_code = aew_pkg::ErrIncomplete;
            state_o.phase    = aew_pkg::PhSeek;
          end else begin
            res_o.kind         = aew_pkg::KindData;
            state_o.words_left = state_i.words_left - 6'd1;
            if (state_i.words_left == 6'd1) begin
              state_o.phase = aew_pkg::PhTrail;
            end
          end
        end
      end
      aew_pkg::PhTrail: begin
        res_o.geo_addr   = state_i.held_geo;
        res_o.crate_id   = state_i.held_crate;
        res_o.word_count = state_i.held_count;
        state_o.phase    = aew_pkg::PhSeek;
        if (wtype != aew_pkg::TypeTrailer) begin
          res_o.kind       = aew_pkg::KindError;
          res_o.error_code = aew_pkg::ErrNotTrailer;
        end else begin
          res_o.kind          = aew_pkg::KindTrailer;
          res_o.event_counter = w[23:0];
          res_o.event_done    = 1'b1;
        end
      end
      default: begin
        state_o.phase = aew_pkg::PhSeek;
        if (w == aew_pkg::FillerWord) begin
          res_o.kind = aew_pkg::KindFiller;
        end else if (wtype != aew_pkg::TypeHeader) begin
          res_o.kind       = aew_pkg::KindError;
          res_o.error_code = aew_pkg::ErrNotHeader;
        end else begin
          state_o.held_geo   = w[31:27];
          state_o.held_crate = w[23:16];
          state_o.held_count = w[13:8];
          res_o.geo_addr     = w[31:27];
          res_o.crate_id     = w[23:16];
          res_o.word_count   = w[13:8];
          if (word_i.buffer_last) begin
            res_o.kind       = aew_pkg::KindError;
            res_o.error_code = aew_pkg::ErrIncomplete;
          end else begin
            res_o.kind         = aew_pkg::KindHeader;
            state_o.words_left = w[13:8];
            state_o.phase      = (w[13:8] == 6'd0) ? aew_pkg::PhTrail : aew_pkg::PhData;
          end
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/adc_event_word_unpacker.sv
// Top level of the ADC event word unpacker.
//
// Input channel (in_valid_i, in_stall_o, in_data_i) carries one 32-bit
// readout word per transaction, with a flag for the last word of a buffer.
// Output channel (out_valid_o, out_stall_i, out_data_o) carries exactly one
// decoded result per input transaction, in order.
// Each word is decoded combinationally against the parser state and the
// result lands in the output register: out_valid_o rises in the cycle after
// acceptance. Throughput is one word per cycle while the receiver does not
// stall; the parser state update is a loop through the decoder.
// A new word is accepted while the output register is empty or holds a
// result that is being taken in the same cycle; when the receiver stalls
// with a result pending, in_stall_o is raised and the result and parser
// state hold. Reset empties the output register and returns the parser to
// header search with cleared held header fields.
module adc_event_word_unpacker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  aew_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output aew_pkg::out_t out_data_o
);

  aew_pkg::state_t state_q, state_d;
  aew_pkg::out_t   res_d, res_q;
  logic            valid_q, valid_d;
  logic            accept;

  aew_decode u_decode (
    .word_i (in_data_i),
    .state_i(state_q),
    .res_o  (res_d),
    .state_o(state_d)
  );

  assign in_stall_o = valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q          <= 1'b0;
      state_q.phase    <= aew_pkg::PhSeek;
      state_q.words_left <= '0;
      state_q.held_geo   <= '0;
      state_q.held_crate <= '0;
      state_q.held_count <= '0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule
